// ===== sv/rktc_pkg.sv =====
// Package for the rolling-key transform chain cipher.
// Holds payload structs, register and operation codes, and the word functions.
// No dependencies; every other file refers to it by scoped names.
package rktc_pkg;

    localparam int MAX_MID    = 5;
    localparam int NUM_IMM    = 5;
    localparam int ADDR_W     = 6;
    localparam int QUEUE_DEPTH = 2;

    // Input actions.
    localparam logic [1:0] ACT_DECRYPT = 2'd0;
    localparam logic [1:0] ACT_ENCRYPT = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    // Step operations; codes above OP_BSWAP leave the value unchanged.
    localparam logic [3:0] OP_XOR   = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_ROL   = 4'd3;
    localparam logic [3:0] OP_ROR   = 4'd4;
    localparam logic [3:0] OP_NEG   = 4'd5;
    localparam logic [3:0] OP_NOT   = 4'd6;
    localparam logic [3:0] OP_INC   = 4'd7;
    localparam logic [3:0] OP_DEC   = 4'd8;
    localparam logic [3:0] OP_BSWAP = 4'd9;

    // Operand size codes.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [63:0] MASK_8  = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] MASK_16 = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STEPS     = 3'd0;
    localparam logic [2:0] REG_SIZE_MODE = 3'd1;
    localparam logic [2:0] REG_OP_CODES  = 3'd2;
    localparam logic [2:0] REG_IMM_1     = 3'd3;
    localparam logic [2:0] REG_IMM_2     = 3'd4;
    localparam logic [2:0] REG_IMM_3     = 3'd5;
    localparam logic [2:0] REG_IMM_4     = 3'd6;
    localparam logic [2:0] REG_IMM_5     = 3'd7;

    typedef enum logic [2:0] {
        KIND_DECRYPT,
        KIND_ENCRYPT,
        KIND_LOAD,
        KIND_PASS,
        KIND_ZERO
    } kind_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] data_word;
    } in_t;

    typedef struct packed {
        logic [63:0] result_word;
        logic [63:0] key_word;
    } out_t;

    typedef struct packed {
        logic [2:0]                chain_length;
        logic [1:0]                size_mode;
        logic [27:0]               op_codes;
        logic [NUM_IMM-1:0][63:0]  step_imm;
    } cfg_t;

    // One classified transaction as it travels from the front to the back.
    typedef struct packed {
        kind_t                     kind;
        logic [1:0]                size;
        logic [63:0]               data;
        logic [3:0]                first_op;
        logic [3:0]                last_op;
        logic [2:0]                mid_cnt;
        logic [MAX_MID-1:0][3:0]   mid_op;
        logic [MAX_MID-1:0][2:0]   mid_sel;
    } entry_t;

    function automatic logic [63:0] size_mask(input logic [1:0] size);
        logic [63:0] m;
        unique case (size)
            SIZE_8:  m = MASK_8;
            SIZE_16: m = MASK_16;
            SIZE_32: m = MASK_32;
            default: m = MASK_64;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] op_inverse(input logic [3:0] op);
        logic [3:0] r;
        case (op)
            OP_ADD:  r = OP_SUB;
            OP_SUB:  r = OP_ADD;
            OP_ROL:  r = OP_ROR;
            OP_ROR:  r = OP_ROL;
            OP_INC:  r = OP_DEC;
            OP_DEC:  r = OP_INC;
            default: r = op;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] op_apply(input logic [3:0]  op,
                                             input logic [63:0] a,
                                             input logic [63:0] b,
                                             input logic [1:0]  size);
        logic [63:0] m;
        logic [63:0] am;
        logic [6:0]  bits;
        logic [6:0]  sh;
        logic [63:0] bs;
        logic [63:0] r;
        m    = size_mask(size);
        am   = a & m;
        bits = 7'd8 << size;
        sh   = {1'b0, b[5:0]} & (bits - 7'd1);
        unique case (size)
            SIZE_8:  bs = am;
            SIZE_16: bs = {48'b0, am[7:0], am[15:8]};
            SIZE_32: bs = {32'b0, am[7:0], am[15:8], am[23:16], am[31:24]};
            default: bs = {am[7:0], am[15:8], am[23:16], am[31:24],
                           am[39:32], am[47:40], am[55:48], am[63:56]};
        endcase
        case (op)
            OP_XOR:  r = a ^ b;
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_ROL:  r = (sh == 7'd0) ? am : ((am << sh) | (am >> (bits - sh)));
            OP_ROR:  r = (sh == 7'd0) ? am : ((am >> sh) | (am << (bits - sh)));
            OP_NEG:  r = 64'd0 - am;
            OP_NOT:  r = ~a;
            OP_INC:  r = a + 64'd1;
            OP_DEC:  r = a - 64'd1;
            OP_BSWAP: r = bs;
            default: r = a;
        endcase
        return r & m;
    endfunction

endpackage

// ===== sv/rktc_cfg.sv =====
// Configuration register file on an APB-style port.
// Depends on rktc_pkg for the register indexes and the cfg_t struct.
module rktc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rktc_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    output rktc_pkg::cfg_t               cfg
);

    logic [2:0]  chain_length_reg;
    logic [1:0]  size_mode_reg;
    logic [27:0] op_codes_reg;
    logic [rktc_pkg::NUM_IMM-1:0][63:0] step_imm_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_length_reg <= 3'd3;
            size_mode_reg    <= rktc_pkg::SIZE_64;
            op_codes_reg     <= 28'd0;
            step_imm_reg     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                rktc_pkg::REG_STEPS:     chain_length_reg <= pwdata[2:0];
                rktc_pkg::REG_SIZE_MODE: size_mode_reg    <= pwdata[1:0];
                rktc_pkg::REG_OP_CODES:  op_codes_reg     <= pwdata[27:0];
                rktc_pkg::REG_IMM_1:     step_imm_reg[0]  <= pwdata;
                rktc_pkg::REG_IMM_2:     step_imm_reg[1]  <= pwdata;
                rktc_pkg::REG_IMM_3:     step_imm_reg[2]  <= pwdata;
                rktc_pkg::REG_IMM_4:     step_imm_reg[3]  <= pwdata;
                rktc_pkg::REG_IMM_5:     step_imm_reg[4]  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rktc_pkg::REG_STEPS:     prdata = {61'd0, chain_length_reg};
            rktc_pkg::REG_SIZE_MODE: prdata = {62'd0, size_mode_reg};
            rktc_pkg::REG_OP_CODES:  prdata = {36'd0, op_codes_reg};
            rktc_pkg::REG_IMM_1:     prdata = step_imm_reg[0];
            rktc_pkg::REG_IMM_2:     prdata = step_imm_reg[1];
            rktc_pkg::REG_IMM_3:     prdata = step_imm_reg[2];
            rktc_pkg::REG_IMM_4:     prdata = step_imm_reg[3];
            rktc_pkg::REG_IMM_5:     prdata = step_imm_reg[4];
            default:                 prdata = 64'd0;
        endcase
    end

    assign cfg.chain_length = chain_length_reg;
    assign cfg.size_mode    = size_mode_reg;
    assign cfg.op_codes     = op_codes_reg;
    assign cfg.step_imm     = step_imm_reg;

endmodule

// ===== sv/rktc_front.sv =====
// Front end: accepts input transactions and classifies them into queue entries.
// Depends on rktc_pkg for the payload, entry and configuration types.
module rktc_front #(
    parameter int MAX_STEPS  = 7,
    parameter int WORD_WIDTH = 64
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  rktc_pkg::in_t       s_data,
    input  rktc_pkg::cfg_t      cfg,
    input  logic                q_full,
    output logic                push,
    output rktc_pkg::entry_t    entry
);

    localparam int MID_SLOTS = MAX_STEPS - 2;
    localparam logic [2:0] MAX_N = 3'(MAX_STEPS);
    localparam logic [1:0] MAX_SIZE = (WORD_WIDTH >= 64) ? 2'd3 :
                                      (WORD_WIDTH >= 32) ? 2'd2 :
                                      (WORD_WIDTH >= 16) ? 2'd1 : 2'd0;

    logic [2:0] n;
    logic [1:0] size;
    logic       is_chain;
    logic       is_dec;
    logic [2:0] step_i;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    assign n    = (cfg.chain_length > MAX_N) ? MAX_N : cfg.chain_length;
    assign size = (cfg.size_mode > MAX_SIZE) ? MAX_SIZE : cfg.size_mode;
    assign is_chain = (n >= 3'd2);
    assign is_dec   = (s_data.action == rktc_pkg::ACT_DECRYPT);

    always_comb begin
        entry          = '0;
        step_i         = 3'd0;
        entry.size     = size;
        entry.data     = s_data.data_word & rktc_pkg::size_mask(size);
        entry.last_op  = cfg.op_codes[4*(n - 3'd1) +: 4];
        entry.first_op = is_dec ? cfg.op_codes[3:0] : rktc_pkg::op_inverse(cfg.op_codes[3:0]);

        unique case (s_data.action)
            rktc_pkg::ACT_DECRYPT: entry.kind = is_chain ? rktc_pkg::KIND_DECRYPT
                                                         : rktc_pkg::KIND_PASS;
            rktc_pkg::ACT_ENCRYPT: entry.kind = is_chain ? rktc_pkg::KIND_ENCRYPT
                                                         : rktc_pkg::KIND_PASS;
            rktc_pkg::ACT_LOAD:    entry.kind = rktc_pkg::KIND_LOAD;
            default:               entry.kind = rktc_pkg::KIND_ZERO;
        endcase

        if (is_chain && (s_data.action == rktc_pkg::ACT_DECRYPT ||
                         s_data.action == rktc_pkg::ACT_ENCRYPT)) begin
            entry.mid_cnt = n - 3'd2;
        end

        // Middle steps are laid out in execution order: forward for decrypt,
        // reversed and inverted for encrypt.
        for (int j = 0; j < MID_SLOTS; j++) begin
            step_i = is_dec ? 3'(j + 1) : (n - 3'd2 - 3'(j));
            if (3'(j) < entry.mid_cnt) begin
                entry.mid_op[j]  = is_dec ? cfg.op_codes[4*step_i +: 4]
                                          : rktc_pkg::op_inverse(cfg.op_codes[4*step_i +: 4]);
                entry.mid_sel[j] = step_i - 3'd1;
            end
        end
    end

endmodule

// ===== sv/rktc_queue.sv =====
// Short queue between the front end and the back end.
// Depends on rktc_pkg for the entry type and the queue depth.
module rktc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rktc_pkg::entry_t  wr_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output rktc_pkg::entry_t  rd_entry
);

    localparam int PTR_W = $clog2(rktc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rktc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(rktc_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(rktc_pkg::QUEUE_DEPTH - 1);

    rktc_pkg::entry_t       mem [rktc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign full     = (count_reg == DEPTH_CNT);
    assign q_valid  = (count_reg != '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== sv/rktc_back.sv =====
// Back end: runs the step chain against the rolling key and holds the result.
// Depends on rktc_pkg for the entry, configuration and result types and op_apply.
module rktc_back #(
    parameter int MAX_STEPS = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  rktc_pkg::entry_t  entry,
    output logic              pop,
    input  rktc_pkg::cfg_t    cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output rktc_pkg::out_t    m_data
);

    localparam int MID_SLOTS = MAX_STEPS - 2;

    logic           m_valid_reg, m_valid_next;
    rktc_pkg::out_t m_data_reg;
    logic [63:0]    key_reg, key_next;
    logic [63:0]    chain_val;
    logic [63:0]    res_val;
    logic [63:0]    key_src;

    assign pop          = q_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = pop || (m_valid_reg && !m_ready);

    // The whole chain, including the key update, is combinational.
    always_comb begin
        chain_val = (entry.kind == rktc_pkg::KIND_DECRYPT)
                  ? rktc_pkg::op_apply(entry.first_op, entry.data, key_reg, entry.size)
                  : entry.data;
        for (int j = 0; j < MID_SLOTS; j++) begin
            if (3'(j) < entry.mid_cnt) begin
                chain_val = rktc_pkg::op_apply(entry.mid_op[j], chain_val,
                                               cfg.step_imm[entry.mid_sel[j]], entry.size);
            end
        end
        key_src  = entry.data;
        res_val  = chain_val;
        key_next = key_reg;
        unique case (entry.kind)
            rktc_pkg::KIND_DECRYPT: begin
                key_src  = chain_val;
                key_next = rktc_pkg::op_apply(entry.last_op, key_reg, key_src, entry.size);
            end
            rktc_pkg::KIND_ENCRYPT: begin
                res_val  = rktc_pkg::op_apply(entry.first_op, chain_val, key_reg, entry.size);
                key_next = rktc_pkg::op_apply(entry.last_op, key_reg, key_src, entry.size);
            end
            rktc_pkg::KIND_LOAD: begin
                key_next = entry.data;
            end
            rktc_pkg::KIND_PASS: ;
            default: begin
                res_val = 64'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            key_reg     <= 64'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                key_reg <= key_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg.result_word <= res_val;
            m_data_reg.key_word    <= key_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/rolling_key_transform_chain_cipher_top.sv =====
// A transaction accepted at the input is written into the queue; the back end pops
// it and registers its result and updated key in the output register.
// Throughput: one transaction per cycle while the output is not stalled; the rolling-key
// loop through the step chain and the key update is combinational in the back end.
// A two-entry queue separates the front end from the back end.
// Reset (aresetn low, synchronous) empties the queue and output, clears the
// rolling key and restores the configuration registers to their defaults.
module rolling_key_transform_chain_cipher_top #(
    parameter int MAX_STEPS  = 7,
    parameter int WORD_WIDTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rktc_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rktc_pkg::out_t               m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rktc_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    rktc_pkg::cfg_t   cfg;
    rktc_pkg::entry_t wr_entry;
    rktc_pkg::entry_t rd_entry;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;

    rktc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rktc_front #(
        .MAX_STEPS  (MAX_STEPS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .q_full  (q_full),
        .push    (push),
        .entry   (wr_entry)
    );

    rktc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .rd_entry (rd_entry)
    );

    rktc_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .entry   (rd_entry),
        .pop     (pop),
        .cfg     (cfg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/rktc_checker.sv =====
// Port-level checker for the rolling-key transform chain cipher, with its bind.
// Depends on rktc_pkg for the payload types and register indexes.
module rktc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input rktc_pkg::out_t               m_data,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [rktc_pkg::ADDR_W-1:0]  paddr,
    input logic [63:0]                  pwdata,
    input logic [63:0]                  prdata,
    input logic                         pready
);

    // The output only becomes valid after an input transaction taken into an empty
    // block has passed through the queue and the output register.
    a_out_follows_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a preceding input transaction");

    // Leaving reset, the block is ready for input and shows no result.
    a_reset_state: assert property (@(posedge aclk)
        $past(!aresetn) |-> (s_ready && !m_valid))
        else $error("block not idle after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // An immediate register reads back what was just written to it.
    a_imm_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(psel && penable && pwrite && pready) && psel && !pwrite &&
         paddr == $past(paddr) && paddr[5:3] >= rktc_pkg::REG_IMM_1)
        |-> (prdata == $past(pwdata)))
        else $error("immediate register readback mismatch");

endmodule

bind rolling_key_transform_chain_cipher_top rktc_checker u_rktc_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rolling_key_transform_chain_cipher_top.
// Depends on rktc_pkg; a scoreboard class predicts every word and rolling key,
// while plain tasks drive the stream ports and the APB configuration port.
module testbench;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [3:0] OP_KEEP    = 4'hF;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 50;

    class cipher_scoreboard;
        logic [2:0]     step_count;
        logic [1:0]     size_sel;
        logic [27:0]    ops;
        logic [63:0]    imm [rktc_pkg::NUM_IMM];
        logic [63:0]    key;
        rktc_pkg::out_t expected_words [$];
        int             errors;

        function new();
            step_count = 3'd3;
            size_sel   = rktc_pkg::SIZE_64;
            ops        = '0;
            key        = '0;
            errors     = 0;
            foreach (imm[i]) imm[i] = '0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [63:0] value);
            case (idx)
                rktc_pkg::REG_STEPS:     step_count = value[2:0];
                rktc_pkg::REG_SIZE_MODE: size_sel = value[1:0];
                rktc_pkg::REG_OP_CODES:  ops = value[27:0];
                default:                 imm[idx - rktc_pkg::REG_IMM_1] = value;
            endcase
        endfunction

        function logic [63:0] ones(input logic [1:0] sz);
            return (sz == rktc_pkg::SIZE_64) ? rktc_pkg::MASK_64
                                             : ((64'd1 << (8 << sz)) - 64'd1);
        endfunction

        function logic [63:0] rotate(input logic [63:0] a, input logic [63:0] b,
                                     input bit left);
            int          bits;
            int          s;
            logic [63:0] m;
            logic [63:0] am;
            bits = 8 << size_sel;
            m    = ones(size_sel);
            am   = a & m;
            s    = int'(b[5:0]) & (bits - 1);
            // A zero amount must not shift by the full width.
            if (s == 0)
                return am;
            if (left)
                return ((am << s) | (am >> (bits - s))) & m;
            return ((am >> s) | (am << (bits - s))) & m;
        endfunction

        function logic [63:0] swap_order(input logic [63:0] a);
            int          nb;
            logic [63:0] am;
            logic [63:0] r;
            nb = (8 << size_sel) / 8;
            am = a & ones(size_sel);
            r  = '0;
            for (int i = 0; i < nb; i++)
                r[8*(nb-1-i) +: 8] = am[8*i +: 8];
            return r;
        endfunction

        function logic [63:0] transform(input logic [3:0] op, input logic [63:0] a,
                                        input logic [63:0] b);
            logic [63:0] r;
            case (op)
                rktc_pkg::OP_XOR:   r = a ^ b;
                rktc_pkg::OP_ADD:   r = a + b;
                rktc_pkg::OP_SUB:   r = a - b;
                rktc_pkg::OP_ROL:   r = rotate(a, b, 1'b1);
                rktc_pkg::OP_ROR:   r = rotate(a, b, 1'b0);
                rktc_pkg::OP_NEG:   r = 64'd0 - a;
                rktc_pkg::OP_NOT:   r = ~a;
                rktc_pkg::OP_INC:   r = a + 64'd1;
                rktc_pkg::OP_DEC:   r = a - 64'd1;
                rktc_pkg::OP_BSWAP: r = swap_order(a);
                default:            r = a;
            endcase
            return r & ones(size_sel);
        endfunction

        function logic [3:0] undo(input logic [3:0] op);
            case (op)
                rktc_pkg::OP_ADD: return rktc_pkg::OP_SUB;
                rktc_pkg::OP_SUB: return rktc_pkg::OP_ADD;
                rktc_pkg::OP_ROL: return rktc_pkg::OP_ROR;
                rktc_pkg::OP_ROR: return rktc_pkg::OP_ROL;
                rktc_pkg::OP_INC: return rktc_pkg::OP_DEC;
                rktc_pkg::OP_DEC: return rktc_pkg::OP_INC;
                default:          return op;
            endcase
        endfunction

        function logic [3:0] op_at(input int step);
            return ops[4*step +: 4];
        endfunction

        function void accept_word(input rktc_pkg::in_t t);
            logic [63:0]    m;
            logic [63:0]    val;
            logic [63:0]    next_key;
            int             n;
            rktc_pkg::out_t e;
            m = ones(size_sel);
            n = step_count;
            if (t.action == rktc_pkg::ACT_LOAD) begin
                key = t.data_word & m;
                val = key;
            end else if (t.action == ACT_UNUSED) begin
                val = '0;
            end else if (n < 2) begin
                val = t.data_word & m;
            end else if (t.action == rktc_pkg::ACT_DECRYPT) begin
                val = transform(op_at(0), t.data_word, key);
                for (int i = 1; i + 1 < n; i++)
                    val = transform(op_at(i), val, imm[i-1]);
                key = transform(op_at(n - 1), key, val);
            end else begin
                // The key update uses the plaintext, so it is the same as for decrypt.
                next_key = transform(op_at(n - 1), key, t.data_word);
                val = t.data_word & m;
                for (int i = n - 2; i >= 1; i--)
                    val = transform(undo(op_at(i)), val, imm[i-1]);
                val = transform(undo(op_at(0)), val, key);
                key = next_key;
            end
            e.result_word = val;
            e.key_word    = key;
            expected_words.insert(expected_words.size(), e);
        endfunction

        function void check_word(input rktc_pkg::out_t got);
            rktc_pkg::out_t e;
            if (expected_words.size() == 0) begin
                $error("unexpected result: result_word %h key_word %h",
                       got.result_word, got.key_word);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (got.result_word !== e.result_word) begin
                $error("result_word: expected %h, got %h", e.result_word, got.result_word);
                errors++;
            end
            if (got.key_word !== e.key_word) begin
                $error("key_word: expected %h, got %h", e.key_word, got.key_word);
                errors++;
            end
        endfunction

        function void flush_check();
            rktc_pkg::out_t e;
            while (expected_words.size() != 0) begin
                e = expected_words.pop_front();
                $error("missing result: result_word %h key_word %h",
                       e.result_word, e.key_word);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    rktc_pkg::in_t               s_data;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    rktc_pkg::out_t              m_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rktc_pkg::ADDR_W-1:0] paddr;
    logic [63:0]                 pwdata;
    logic [63:0]                 prdata;
    logic                        pready;
    bit                          quiet = 1'b0;
    cipher_scoreboard            sb;

    rolling_key_transform_chain_cipher_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.accept_word(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_data);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [2:0] chain, input logic [1:0] size,
                             input logic [27:0] ops, input logic [63:0] i1,
                             input logic [63:0] i2, input logic [63:0] i3,
                             input logic [63:0] i4, input logic [63:0] i5);
        write_reg(rktc_pkg::REG_STEPS, {61'd0, chain});
        write_reg(rktc_pkg::REG_SIZE_MODE, {62'd0, size});
        write_reg(rktc_pkg::REG_OP_CODES, {36'd0, ops});
        write_reg(rktc_pkg::REG_IMM_1, i1);
        write_reg(rktc_pkg::REG_IMM_2, i2);
        write_reg(rktc_pkg::REG_IMM_3, i3);
        write_reg(rktc_pkg::REG_IMM_4, i4);
        write_reg(rktc_pkg::REG_IMM_5, i5);
    endtask

    task automatic send_word(input logic [1:0] act, input logic [63:0] word);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_data.action    = act;
        s_data.data_word = word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain();
        int waited;
        @(negedge aclk);
        s_valid = 1'b0;
        waited  = 0;
        while (sb.expected_words.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return rktc_pkg::MASK_64;
            2:       return 64'($urandom_range(0, 130));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_setting();
        logic [27:0] ops;
        logic [2:0]  chain;
        int          r;
        r = $urandom_range(0, 9);
        chain = (r == 0) ? 3'd0 : (r == 1) ? 3'd1 : 3'($urandom_range(2, 7));
        for (int k = 0; k < 7; k++)
            ops[4*k +: 4] = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                                          : 4'($urandom_range(10, 15));
        configure(chain, 2'($urandom_range(0, 3)), ops, pick_word(), pick_word(),
                  pick_word(), pick_word(), pick_word());
    endtask

    initial begin
        int          r;
        logic [1:0]  act;
        sb       = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset configuration: three xor steps at 64 bits.
        send_word(rktc_pkg::ACT_LOAD, 64'h0123_4567_89AB_CDEF);
        send_word(rktc_pkg::ACT_DECRYPT, 64'd0);
        send_word(rktc_pkg::ACT_DECRYPT, rktc_pkg::MASK_64);
        send_word(rktc_pkg::ACT_ENCRYPT, rktc_pkg::MASK_64);
        send_word(ACT_UNUSED, rktc_pkg::MASK_64);
        send_word(rktc_pkg::ACT_LOAD, rktc_pkg::MASK_64);
        drain();

        // Longest chain at 64 bits; a zero key and a key of 64 both rotate by zero.
        configure(3'd7, rktc_pkg::SIZE_64,
                  {rktc_pkg::OP_BSWAP, rktc_pkg::OP_NOT, rktc_pkg::OP_NEG,
                   rktc_pkg::OP_ROR, rktc_pkg::OP_SUB, rktc_pkg::OP_ADD,
                   rktc_pkg::OP_ROL},
                  64'd0, rktc_pkg::MASK_64, 64'd64, 64'd1, 64'h8000_0000_0000_0000);
        send_word(rktc_pkg::ACT_LOAD, 64'd0);
        send_word(rktc_pkg::ACT_DECRYPT, 64'h8000_0000_0000_0001);
        send_word(rktc_pkg::ACT_ENCRYPT, 64'h8000_0000_0000_0001);
        send_word(rktc_pkg::ACT_LOAD, 64'd64);
        send_word(rktc_pkg::ACT_DECRYPT, rktc_pkg::MASK_64);
        send_word(rktc_pkg::ACT_ENCRYPT, 64'd0);
        drain();

        // Byte swap at 8 bits leaves the value alone; the key load is masked.
        configure(3'd7, rktc_pkg::SIZE_8,
                  {rktc_pkg::OP_ADD, OP_KEEP, rktc_pkg::OP_BSWAP, rktc_pkg::OP_XOR,
                   rktc_pkg::OP_DEC, rktc_pkg::OP_INC, rktc_pkg::OP_ROR},
                  rktc_pkg::MASK_64, rktc_pkg::MASK_8, 64'd8, 64'h80, 64'd0);
        send_word(rktc_pkg::ACT_LOAD, 64'h1FF);
        send_word(rktc_pkg::ACT_DECRYPT, rktc_pkg::MASK_8);
        send_word(rktc_pkg::ACT_ENCRYPT, 64'd0);
        send_word(rktc_pkg::ACT_DECRYPT, rktc_pkg::MASK_64);
        send_word(ACT_UNUSED, 64'd5);
        drain();

        // Chains shorter than two steps pass the masked word through.
        configure(3'd0, rktc_pkg::SIZE_16, 28'hFFF_FFFF, rktc_pkg::MASK_64,
                  rktc_pkg::MASK_64, rktc_pkg::MASK_64, rktc_pkg::MASK_64,
                  rktc_pkg::MASK_64);
        send_word(rktc_pkg::ACT_DECRYPT, rktc_pkg::MASK_64);
        send_word(rktc_pkg::ACT_ENCRYPT, 64'h1234_5678_9ABC_DEF0);
        send_word(rktc_pkg::ACT_LOAD, rktc_pkg::MASK_64);
        drain();
        configure(3'd1, rktc_pkg::SIZE_32, 28'h123_4567, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_word(rktc_pkg::ACT_DECRYPT, rktc_pkg::MASK_64);
        send_word(rktc_pkg::ACT_ENCRYPT, rktc_pkg::MASK_64);
        drain();
        configure(3'd2, rktc_pkg::SIZE_16, {20'd0, rktc_pkg::OP_ADD, OP_KEEP},
                  64'd3, 64'd0, 64'd0, 64'd0, 64'd0);
        send_word(rktc_pkg::ACT_DECRYPT, 64'hFEDC_BA98_7654_3210);
        send_word(rktc_pkg::ACT_ENCRYPT, 64'h0000_0000_0000_FFFF);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_setting();
            quiet = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                act = (r < 10) ? rktc_pkg::ACT_LOAD : (r < 14) ? ACT_UNUSED :
                      (r < 57) ? rktc_pkg::ACT_DECRYPT : rktc_pkg::ACT_ENCRYPT;
                send_word(act, pick_word());
            end
            drain();
            quiet = 1'b0;
        end

        sb.flush_check();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rktc_pkg.sv
sv/rktc_cfg.sv
sv/rktc_front.sv
sv/rktc_queue.sv
sv/rktc_back.sv
sv/rolling_key_transform_chain_cipher_top.sv
sv/rktc_checker.sv
dv/testbench.sv
